// ===== hw/rtl/vstp_pkg.sv =====
// Package for the vendor sub-element TLV parser: payload word types,
// result and status codes, table constants and the saturating counter helper.
// No dependencies.
`timescale 1ns / 1ps

package vstp_pkg;

    localparam int NUM_REGS          = 4;
    localparam int MAX_TABLE_ENTRIES = 8;
    localparam int HDR_BYTES         = 8;
    localparam int HDR_POS_W         = $clog2(HDR_BYTES);
    localparam int ENTRY_W           = 64;
    localparam int QUEUE_DEPTH       = 4;
    localparam int CFG_ADDR_W        = $clog2(NUM_REGS * 8);

    localparam logic [1:0] KIND_VALUE    = 2'd0;
    localparam logic [1:0] KIND_ACCEPTED = 2'd1;
    localparam logic [1:0] KIND_REJECTED = 2'd2;
    localparam logic [1:0] KIND_FINISHED = 2'd3;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_SHORT_HDR = 2'd1;
    localparam logic [1:0] STATUS_OVERRUN   = 2'd2;

    typedef logic [ENTRY_W-1:0] entry_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  entry_index;
        logic [31:0] vendor_code;
        logic [15:0] subtype;
        logic [15:0] declared_length;
        logic [15:0] kept_length;
        logic        truncated;
        logic [7:0]  value_byte;
        logic [1:0]  status;
        logic [15:0] accepted_count;
        logic [15:0] rejected_count;
        logic        last_of_run;
    } out_word_t;

    typedef struct packed {
        logic [1:0] count;
        out_word_t  first;
        out_word_t  second;
    } parse_out_t;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

endpackage

// ===== hw/rtl/vendor_subelement_tlv_parser.sv =====
// Top level of the vendor sub-element TLV parser: APB table registers,
// input register, parser and result queue. Depends on vstp_pkg,
// vstp_parser and vstp_out_queue.
//
//   port group   dir   payload       handshake
//   s_*          in    in_word_t     s_valid / s_ready
//   m_*          out   out_word_t    m_valid / m_ready
//   p*           in    64-bit regs   psel / penable / pwrite, pready tied high
//
// One byte per cycle sustained while s_ready is high; each byte is registered on
// input, and its results are queued for m_word. A header's last byte with the
// buffer's last byte yields two words, drained at one per cycle while m_ready is
// high by the four-word result queue. s_ready drops only while the queue holds
// more than two words. Synchronous active-low reset clears parse state and table.
`timescale 1ns / 1ps

module vendor_subelement_tlv_parser #(
    parameter int TABLE_ENTRIES = vstp_pkg::NUM_REGS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  vstp_pkg::in_word_t                s_word,
    output logic                              m_valid,
    input  logic                              m_ready,
    output vstp_pkg::out_word_t               m_word,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [vstp_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [vstp_pkg::ENTRY_W-1:0]      pwdata,
    output logic [vstp_pkg::ENTRY_W-1:0]      prdata,
    output logic                              pready
);
    import vstp_pkg::*;

    localparam int IDX_W = $clog2(NUM_REGS);

    entry_t     entry_reg [NUM_REGS];
    logic       in_valid_reg;
    in_word_t   in_word_reg;
    logic       room;
    logic       proc_fire;
    logic [IDX_W-1:0] reg_idx;
    parse_out_t parse_res;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[CFG_ADDR_W-1:3];
    assign prdata    = entry_reg[reg_idx];
    assign proc_fire = in_valid_reg && room;
    assign s_ready   = !in_valid_reg || room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                entry_reg[i] <= '0;
            end
        end else if (psel && penable && pwrite && pready) begin
            entry_reg[reg_idx] <= pwdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (proc_fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_word;
        end
    end

    vstp_parser #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (proc_fire),
        .in_word (in_word_reg),
        .entries (entry_reg),
        .result  (parse_res)
    );

    vstp_out_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (proc_fire),
        .push_data (parse_res),
        .room      (room),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word)
    );

endmodule

// ===== hw/rtl/vstp_parser.sv =====
// Parse state and header match: turns one byte into up to two result words.
// Depends on vstp_pkg.
`timescale 1ns / 1ps

module vstp_parser #(
    parameter int TABLE_ENTRIES = vstp_pkg::NUM_REGS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 fire,
    input  vstp_pkg::in_word_t   in_word,
    input  vstp_pkg::entry_t     entries [vstp_pkg::NUM_REGS],
    output vstp_pkg::parse_out_t result
);
    import vstp_pkg::*;

    localparam int SCAN_ENTRIES = (TABLE_ENTRIES < NUM_REGS) ? TABLE_ENTRIES : NUM_REGS;

    logic [55:0]          hdr_reg, hdr_next;
    logic [HDR_POS_W-1:0] pos_reg, pos_next;
    logic                 in_payload_reg, in_payload_next;
    logic [15:0]          payload_left_reg, payload_left_next;
    logic [15:0]          keep_left_reg, keep_left_next;
    logic [1:0]           cur_entry_reg, cur_entry_next;
    logic                 cur_allowed_reg, cur_allowed_next;
    logic [15:0]          acc_reg, acc_next;
    logic [15:0]          rej_reg, rej_next;

    always_comb begin
        logic [63:0] full_hdr;
        logic [31:0] vendor;
        logic [15:0] dlen;
        logic [15:0] subtype;
        logic        found;
        logic        ended;
        logic [1:0]  hit_idx;
        logic [15:0] hit_max;
        logic [15:0] kept;
        logic        has_first;
        logic [1:0]  fin_status;
        out_word_t   first_w;
        out_word_t   final_w;

        full_hdr = {hdr_reg, in_word.data_byte};
        vendor   = full_hdr[63:32];
        subtype  = full_hdr[31:16];
        dlen     = full_hdr[15:0];
        found    = 1'b0;
        ended    = 1'b0;
        hit_idx  = '0;
        hit_max  = '0;
        for (int i = 0; i < SCAN_ENTRIES; i++) begin
            if (!found && !ended) begin
                if (entries[i][63:48] == 16'd0) begin
                    ended = 1'b1;
                end else if (entries[i][31:0] == vendor && entries[i][47:32] == subtype) begin
                    found   = 1'b1;
                    hit_idx = 2'(i);
                    hit_max = entries[i][63:48];
                end
            end
        end
        kept = (dlen > hit_max) ? hit_max : dlen;

        hdr_next          = hdr_reg;
        pos_next          = pos_reg;
        in_payload_next   = in_payload_reg;
        payload_left_next = payload_left_reg;
        keep_left_next    = keep_left_reg;
        cur_entry_next    = cur_entry_reg;
        cur_allowed_next  = cur_allowed_reg;
        acc_next          = acc_reg;
        rej_next          = rej_reg;
        has_first         = 1'b0;
        first_w           = '0;
        final_w           = '0;
        fin_status        = STATUS_OK;

        if (!in_payload_reg) begin
            hdr_next = full_hdr[55:0];
            if (pos_reg != HDR_POS_W'(HDR_BYTES - 1)) begin
                pos_next   = pos_reg + 1'b1;
                fin_status = STATUS_SHORT_HDR;
            end else begin
                pos_next                = '0;
                has_first               = 1'b1;
                first_w.vendor_code     = vendor;
                first_w.subtype         = subtype;
                first_w.declared_length = dlen;
                if (found) begin
                    cur_allowed_next    = 1'b1;
                    cur_entry_next      = hit_idx;
                    keep_left_next      = kept;
                    first_w.kind        = KIND_ACCEPTED;
                    first_w.entry_index = hit_idx;
                    first_w.kept_length = kept;
                    first_w.truncated   = (dlen > hit_max);
                    acc_next            = sat_inc(acc_reg);
                end else begin
                    cur_allowed_next = 1'b0;
                    cur_entry_next   = '0;
                    keep_left_next   = '0;
                    first_w.kind     = KIND_REJECTED;
                    rej_next         = sat_inc(rej_reg);
                end
                payload_left_next = dlen;
                in_payload_next   = (dlen != 16'd0);
                fin_status        = in_payload_next ? STATUS_OVERRUN : STATUS_OK;
            end
        end else begin
            if (cur_allowed_reg && keep_left_reg != 16'd0) begin
                has_first           = 1'b1;
                first_w.kind        = KIND_VALUE;
                first_w.entry_index = cur_entry_reg;
                first_w.value_byte  = in_word.data_byte;
                keep_left_next      = keep_left_reg - 16'd1;
            end
            if (payload_left_reg != 16'd0) begin
                payload_left_next = payload_left_reg - 16'd1;
            end
            if (payload_left_next == 16'd0) begin
                in_payload_next = 1'b0;
                keep_left_next  = '0;
            end
            fin_status = in_payload_next ? STATUS_OVERRUN : STATUS_OK;
        end

        final_w.kind           = KIND_FINISHED;
        final_w.status         = fin_status;
        final_w.accepted_count = (fin_status == STATUS_SHORT_HDR) ? 16'd0 : acc_next;
        final_w.rejected_count = rej_next;
        final_w.last_of_run    = 1'b1;
        first_w.last_of_run    = !in_word.last_byte;

        if (in_word.last_byte) begin
            hdr_next          = '0;
            pos_next          = '0;
            in_payload_next   = 1'b0;
            payload_left_next = '0;
            keep_left_next    = '0;
            cur_entry_next    = '0;
            cur_allowed_next  = 1'b0;
            acc_next          = '0;
            rej_next          = '0;
        end

        result.count  = 2'(has_first) + 2'(in_word.last_byte);
        result.first  = has_first ? first_w : final_w;
        result.second = final_w;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_reg          <= '0;
            pos_reg          <= '0;
            in_payload_reg   <= 1'b0;
            payload_left_reg <= '0;
            keep_left_reg    <= '0;
            cur_entry_reg    <= '0;
            cur_allowed_reg  <= 1'b0;
            acc_reg          <= '0;
            rej_reg          <= '0;
        end else if (fire) begin
            hdr_reg          <= hdr_next;
            pos_reg          <= pos_next;
            in_payload_reg   <= in_payload_next;
            payload_left_reg <= payload_left_next;
            keep_left_reg    <= keep_left_next;
            cur_entry_reg    <= cur_entry_next;
            cur_allowed_reg  <= cur_allowed_next;
            acc_reg          <= acc_next;
            rej_reg          <= rej_next;
        end
    end

endmodule

// ===== hw/rtl/vstp_out_queue.sv =====
// Result queue: takes zero, one or two words per cycle, hands out one while m_ready is high.
// Depends on vstp_pkg.
`timescale 1ns / 1ps

module vstp_out_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  vstp_pkg::parse_out_t push_data,
    output logic                 room,
    output logic                 m_valid,
    input  logic                 m_ready,
    output vstp_pkg::out_word_t  m_word
);
    import vstp_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    out_word_t          slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [1:0]         push_count;
    logic               pop;

    assign push_count = push ? push_data.count : 2'd0;
    assign pop        = m_valid && m_ready;
    assign m_valid    = (count_reg != '0);
    assign m_word     = slot_reg[rd_ptr_reg];
    assign room       = (count_reg <= CNT_W'(QUEUE_DEPTH - 2));
    assign count_next = count_reg + CNT_W'(push_count) - CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (push_count != 2'd0) begin
            slot_reg[wr_ptr_reg] <= push_data.first;
        end
        if (push_count == 2'd2) begin
            slot_reg[wr_ptr_reg + 1'b1] <= push_data.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_count);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(pop);
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("result queue over capacity");

    a_push_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_count != 2'd0) |-> room)
        else $error("push without room");

    a_pop_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && push_count == 2'd0) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("pop did not drain one word");

endmodule
